[hdl/necir_pkg.sv]
`default_nettype none

package necir_pkg;

  localparam int unsigned NOM_WIDTH   = 16;
  localparam int unsigned WIN_WIDTH   = 32;
  localparam int unsigned CFG_WIDTH   = 32;
  localparam int unsigned IDX_WIDTH   = 3;
  localparam int unsigned STAMP_WIDTH = 32;
  localparam int unsigned ADDR_WIDTH  = 16;
  localparam int unsigned CMD_WIDTH   = 8;
  localparam int unsigned SHIFT_WIDTH = 32;
  localparam int unsigned CNT_WIDTH   = 6;

  localparam logic [NOM_WIDTH-1:0] LEADER_MARK_RST   = 16'd9000;
  localparam logic [NOM_WIDTH-1:0] FRAME_SPACE_RST   = 16'd4500;
  localparam logic [NOM_WIDTH-1:0] REPEAT_SPACE_RST  = 16'd2250;
  localparam logic [NOM_WIDTH-1:0] BIT_MARK_RST      = 16'd562;
  localparam logic [NOM_WIDTH-1:0] ZERO_SPACE_RST    = 16'd562;
  localparam logic [NOM_WIDTH-1:0] ONE_SPACE_RST     = 16'd1687;
  localparam logic [WIN_WIDTH-1:0] REPEAT_WINDOW_RST = 32'd250000;

  localparam logic [CNT_WIDTH-1:0] FRAME_BITS = 6'd32;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_LEADER_MARK   = 3'd0,
    REG_FRAME_SPACE   = 3'd1,
    REG_REPEAT_SPACE  = 3'd2,
    REG_BIT_MARK      = 3'd3,
    REG_ZERO_SPACE    = 3'd4,
    REG_ONE_SPACE     = 3'd5,
    REG_REPEAT_WINDOW = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_FRAME  = 2'd2,
    PH_REPEAT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CODE_NONE   = 2'd0,
    CODE_FRAME  = 2'd1,
    CODE_REPEAT = 2'd2
  } code_e;

  typedef struct packed {
    logic [NOM_WIDTH-1:0] leader_mark;
    logic [NOM_WIDTH-1:0] frame_space;
    logic [NOM_WIDTH-1:0] repeat_space;
    logic [NOM_WIDTH-1:0] bit_mark;
    logic [NOM_WIDTH-1:0] zero_space;
    logic [NOM_WIDTH-1:0] one_space;
    logic [WIN_WIDTH-1:0] repeat_window;
  } cfg_t;

  typedef struct packed {
    logic                  received;
    logic                  is_repeat;
    logic [ADDR_WIDTH-1:0] address;
    logic [CMD_WIDTH-1:0]  command;
  } res_t;

endpackage

`default_nettype wire

[hdl/necir_cfg.sv]
`default_nettype none

module necir_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [necir_pkg::IDX_WIDTH-1:0] cfg_index_i,
  input  wire logic [necir_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  output necir_pkg::cfg_t                      cfg_o
);
  import necir_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_LEADER_MARK:   cfg_d.leader_mark   = cfg_wdata_i[NOM_WIDTH-1:0];
        REG_FRAME_SPACE:   cfg_d.frame_space   = cfg_wdata_i[NOM_WIDTH-1:0];
        REG_REPEAT_SPACE:  cfg_d.repeat_space  = cfg_wdata_i[NOM_WIDTH-1:0];
        REG_BIT_MARK:      cfg_d.bit_mark      = cfg_wdata_i[NOM_WIDTH-1:0];
        REG_ZERO_SPACE:    cfg_d.zero_space    = cfg_wdata_i[NOM_WIDTH-1:0];
        REG_ONE_SPACE:     cfg_d.one_space     = cfg_wdata_i[NOM_WIDTH-1:0];
        REG_REPEAT_WINDOW: cfg_d.repeat_window = cfg_wdata_i[WIN_WIDTH-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_mark   <= LEADER_MARK_RST;
      cfg_q.frame_space   <= FRAME_SPACE_RST;
      cfg_q.repeat_space  <= REPEAT_SPACE_RST;
      cfg_q.bit_mark      <= BIT_MARK_RST;
      cfg_q.zero_space    <= ZERO_SPACE_RST;
      cfg_q.one_space     <= ONE_SPACE_RST;
      cfg_q.repeat_window <= REPEAT_WINDOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/necir_core.sv]
`default_nettype none

module necir_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  item_valid_i,
  input  wire logic                  poll_i,
  input  wire logic                  mark_i,
  input  wire logic [TIME_WIDTH-1:0] time_i,
  input  necir_pkg::cfg_t            cfg_i,
  output necir_pkg::res_t            res_o
);
  import necir_pkg::*;

  localparam int unsigned MW = TIME_WIDTH + NOM_WIDTH + 1;

  function automatic logic in_tol(logic [TIME_WIDTH-1:0] w, logic [NOM_WIDTH-1:0] nom);
    logic [NOM_WIDTH:0] lo;
    logic [NOM_WIDTH:0] hi;
    logic [MW-1:0]      w_x;
    lo  = {1'b0, nom} - {3'b000, nom[NOM_WIDTH-1:2]};
    hi  = {1'b0, nom} + {3'b000, nom[NOM_WIDTH-1:2]};
    w_x = {{(NOM_WIDTH+1){1'b0}}, w};
    return (w_x >= {{TIME_WIDTH{1'b0}}, lo}) && (w_x <= {{TIME_WIDTH{1'b0}}, hi});
  endfunction

  phase_e                  phase_q, phase_d;
  code_e                   code_q, code_d;
  logic [TIME_WIDTH-1:0]   prev_q, prev_d;
  logic [TIME_WIDTH-1:0]   held_q, held_d;
  logic [SHIFT_WIDTH-1:0]  shift_q, shift_d;
  logic [CNT_WIDTH-1:0]    count_q, count_d;
  logic                    held_flag_q, held_flag_d;
  logic [ADDR_WIDTH-1:0]   pend_addr_q, pend_addr_d;
  logic [CMD_WIDTH-1:0]    pend_cmd_q, pend_cmd_d;
  logic [ADDR_WIDTH-1:0]   shown_addr_q, shown_addr_d;
  logic [CMD_WIDTH-1:0]    shown_cmd_q, shown_cmd_d;

  logic [TIME_WIDTH-1:0]   width;
  logic [TIME_WIDTH-1:0]   since;
  logic                    in_window;
  logic                    m_leader, m_frame_sp, m_repeat_sp, m_bit, m_zero, m_one;
  logic [7:0]              b0, b1, b2, b3;

  assign width       = time_i - prev_q;
  assign since       = time_i - held_q;
  assign in_window   = {{WIN_WIDTH{1'b0}}, since} < {{TIME_WIDTH{1'b0}}, cfg_i.repeat_window};
  assign m_leader    = in_tol(width, cfg_i.leader_mark);
  assign m_frame_sp  = in_tol(width, cfg_i.frame_space);
  assign m_repeat_sp = in_tol(width, cfg_i.repeat_space);
  assign m_bit       = in_tol(width, cfg_i.bit_mark);
  assign m_zero      = in_tol(width, cfg_i.zero_space);
  assign m_one       = in_tol(width, cfg_i.one_space);
  assign b0          = shift_q[7:0];
  assign b1          = shift_q[15:8];
  assign b2          = shift_q[23:16];
  assign b3          = shift_q[31:24];

  always_comb begin
    phase_d      = phase_q;
    code_d       = code_q;
    prev_d       = prev_q;
    held_d       = held_q;
    shift_d      = shift_q;
    count_d      = count_q;
    held_flag_d  = held_flag_q;
    pend_addr_d  = pend_addr_q;
    pend_cmd_d   = pend_cmd_q;
    shown_addr_d = shown_addr_q;
    shown_cmd_d  = shown_cmd_q;

    if (item_valid_i && poll_i) begin
      code_d = CODE_NONE;
      if (code_q == CODE_FRAME) begin
        shown_addr_d = pend_addr_q;
        shown_cmd_d  = pend_cmd_q;
      end
    end else if (item_valid_i) begin
      prev_d = time_i;
      if (mark_i && m_leader) begin
        phase_d = PH_LEAD;
      end else begin
        unique case (phase_q)
          PH_WAIT: begin
            phase_d = PH_WAIT;
          end
          PH_LEAD: begin
            if (!mark_i && m_frame_sp) begin
              phase_d     = PH_FRAME;
              shift_d     = '0;
              count_d     = '0;
              held_flag_d = 1'b0;
            end else if (!mark_i && m_repeat_sp) begin
              phase_d = PH_REPEAT;
            end else begin
              phase_d = PH_WAIT;
            end
          end
          PH_FRAME: begin
            if (!mark_i) begin
              if (count_q >= FRAME_BITS || !(m_one || m_zero)) begin
                phase_d = PH_WAIT;
              end else begin
                if (m_one) begin
                  shift_d = shift_q | (SHIFT_WIDTH'(1) << count_q[CNT_WIDTH-2:0]);
                end
                count_d = count_q + CNT_WIDTH'(1);
              end
            end else if (!m_bit) begin
              phase_d = PH_WAIT;
            end else if (count_q == FRAME_BITS) begin
              phase_d = PH_WAIT;
              if (~b2 == b3) begin
                pend_addr_d = (~b0 == b1) ? {8'h00, b0} : shift_q[ADDR_WIDTH-1:0];
                pend_cmd_d  = b2;
                code_d      = CODE_FRAME;
                held_flag_d = 1'b1;
                held_d      = time_i;
              end
            end
          end
          PH_REPEAT: begin
            if (mark_i && m_bit && held_flag_q && in_window) begin
              held_d = time_i;
              if (code_q == CODE_NONE) begin
                code_d = CODE_REPEAT;
              end
            end
            phase_d = PH_WAIT;
          end
          default: begin
            phase_d = PH_WAIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT;
      code_q       <= CODE_NONE;
      prev_q       <= '0;
      held_q       <= '0;
      shift_q      <= '0;
      count_q      <= '0;
      held_flag_q  <= 1'b0;
      pend_addr_q  <= '0;
      pend_cmd_q   <= '0;
      shown_addr_q <= '0;
      shown_cmd_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      code_q       <= code_d;
      prev_q       <= prev_d;
      held_q       <= held_d;
      shift_q      <= shift_d;
      count_q      <= count_d;
      held_flag_q  <= held_flag_d;
      pend_addr_q  <= pend_addr_d;
      pend_cmd_q   <= pend_cmd_d;
      shown_addr_q <= shown_addr_d;
      shown_cmd_q  <= shown_cmd_d;
    end
  end

  always_comb begin
    res_o.received  = (code_q != CODE_NONE);
    res_o.is_repeat = (code_q == CODE_REPEAT);
    res_o.address   = shown_addr_d;
    res_o.command   = shown_cmd_d;
  end

endmodule

`default_nettype wire

[hdl/nec_ir_decoder.sv]
// nec infrared remote decoder working from timestamped line edges
// input stream: tuser[0] kind (0 edge, 1 poll), tuser[1] mark_ended,
//   tdata edge timestamp in microseconds, ignored for a poll
// output stream: one transfer per poll, tuser flags received and is_repeat,
//   tdata address and command of the last collected frame
// configuration: write enable, register index and data; nominal pulse times
//   and repeat window take effect from the next transfer
// path: an input transfer is registered, then decoded from the input register
//   and a poll result lands in the output register, where it can be taken
// throughput: one input transfer per cycle while no poll waits on a stalled output,
//   set by the single decode stage between the input register and the output register
// a stalled output holds its result; edges keep flowing past it, a further
//   poll waits in the input register until the result is taken
// reset clears the decoder to waiting for a leader with nothing pending and
//   loads the standard nec timings
`default_nettype none

module nec_ir_decoder #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // edge_time
  input  wire logic [1:0]  s_axis_tuser,   // kind, mark_ended
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // address, command
  output logic [1:0]       m_axis_tuser,   // received, is_repeat
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import necir_pkg::*;

  logic                   in_valid_q;
  logic                   in_kind_q;
  logic                   in_mark_q;
  logic [STAMP_WIDTH-1:0] in_time_q;
  logic                   advance;
  logic [TIME_WIDTH+STAMP_WIDTH-1:0] time_ext;
  cfg_t                   cfg;
  res_t                   res;
  res_t                   out_q;
  logic                   out_valid_q;

  assign advance       = in_valid_q && (!in_kind_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign time_ext      = {{TIME_WIDTH{1'b0}}, in_time_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser[0];
      in_mark_q <= s_axis_tuser[1];
      in_time_q <= s_axis_tdata;
    end
  end

  necir_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  necir_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (advance),
    .poll_i       (in_kind_q),
    .mark_i       (in_mark_q),
    .time_i       (time_ext[TIME_WIDTH-1:0]),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_kind_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_kind_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.command, out_q.address};
  assign m_axis_tuser  = {out_q.is_repeat, out_q.received};

endmodule

`default_nettype wire

[tb/sv/ir_check_pkg.sv]
`timescale 1ns / 1ps

package ir_check_pkg;

  import necir_pkg::*;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  class ir_poll_checker;
    cfg_t        cfg;
    logic [31:0] last_stamp;
    logic [31:0] held_since;
    logic [31:0] shift_reg;
    phase_e      phase;
    logic [5:0]  nbits;
    logic        held;
    code_e       code;
    logic [15:0] pend_addr;
    logic [15:0] shown_addr;
    logic [7:0]  pend_cmd;
    logic [7:0]  shown_cmd;
    res_t        poll_replies[$];
    int          errors;
    int          replies;
    int          frames;
    int          repeats;

    function new();
      cfg.leader_mark   = LEADER_MARK_RST;
      cfg.frame_space   = FRAME_SPACE_RST;
      cfg.repeat_space  = REPEAT_SPACE_RST;
      cfg.bit_mark      = BIT_MARK_RST;
      cfg.zero_space    = ZERO_SPACE_RST;
      cfg.one_space     = ONE_SPACE_RST;
      cfg.repeat_window = REPEAT_WINDOW_RST;
      last_stamp = '0;
      held_since = '0;
      shift_reg  = '0;
      phase      = PH_WAIT;
      nbits      = '0;
      held       = 1'b0;
      code       = CODE_NONE;
      pend_addr  = '0;
      shown_addr = '0;
      pend_cmd   = '0;
      shown_cmd  = '0;
      errors     = 0;
      replies    = 0;
      frames     = 0;
      repeats    = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] val);
      case (idx)
        REG_LEADER_MARK:   cfg.leader_mark   = val[15:0];
        REG_FRAME_SPACE:   cfg.frame_space   = val[15:0];
        REG_REPEAT_SPACE:  cfg.repeat_space  = val[15:0];
        REG_BIT_MARK:      cfg.bit_mark      = val[15:0];
        REG_ZERO_SPACE:    cfg.zero_space    = val[15:0];
        REG_ONE_SPACE:     cfg.one_space     = val[15:0];
        REG_REPEAT_WINDOW: cfg.repeat_window = val;
        default: ;
      endcase
    endfunction

    // nominal plus or minus a quarter, rounded down
    function bit near_nom(logic [31:0] w, logic [15:0] nom);
      logic [31:0] n;
      n = {16'h0, nom};
      return (w >= n - (n >> 2)) && (w <= n + (n >> 2));
    endfunction

    function void take_frame(logic [31:0] stamp);
      logic [7:0] b0, b1, b2, b3, inv0, inv2;
      b0 = shift_reg[7:0];
      b1 = shift_reg[15:8];
      b2 = shift_reg[23:16];
      b3 = shift_reg[31:24];
      inv0 = ~b0;
      inv2 = ~b2;
      if (inv2 != b3) return;
      pend_addr  = (inv0 == b1) ? {8'h00, b0} : shift_reg[15:0];
      pend_cmd   = b2;
      code       = CODE_FRAME;
      held       = 1'b1;
      held_since = stamp;
    endfunction

    function void decode_edge(logic [31:0] stamp, logic mark);
      logic [31:0] w;
      bit          one;
      w = stamp - last_stamp;
      last_stamp = stamp;
      if (mark && near_nom(w, cfg.leader_mark)) begin
        phase = PH_LEAD;
        return;
      end
      case (phase)
        PH_LEAD: begin
          if (!mark && near_nom(w, cfg.frame_space)) begin
            phase     = PH_FRAME;
            shift_reg = '0;
            nbits     = '0;
            held      = 1'b0;
          end else if (!mark && near_nom(w, cfg.repeat_space)) begin
            phase = PH_REPEAT;
          end else begin
            phase = PH_WAIT;
          end
        end
        PH_FRAME: begin
          if (!mark) begin
            one = near_nom(w, cfg.one_space);
            if (nbits >= FRAME_BITS || !(one || near_nom(w, cfg.zero_space))) begin
              phase = PH_WAIT;
            end else begin
              if (one) shift_reg[nbits[4:0]] = 1'b1;
              nbits = nbits + 6'd1;
            end
          end else if (!near_nom(w, cfg.bit_mark)) begin
            phase = PH_WAIT;
          end else if (nbits == FRAME_BITS) begin
            take_frame(stamp);
            phase = PH_WAIT;
          end
        end
        PH_REPEAT: begin
          if (mark && near_nom(w, cfg.bit_mark) && held &&
              (stamp - held_since) < cfg.repeat_window) begin
            held_since = stamp;
            if (code == CODE_NONE) code = CODE_REPEAT;
          end
          phase = PH_WAIT;
        end
        default: ;
      endcase
    endfunction

    function void note_transfer(logic kind_bit, logic [31:0] stamp, logic mark);
      code_e was;
      res_t  r;
      if (kind_bit == KIND_EDGE) begin
        decode_edge(stamp, mark);
        return;
      end
      was  = code;
      code = CODE_NONE;
      if (was == CODE_FRAME) begin
        shown_addr = pend_addr;
        shown_cmd  = pend_cmd;
      end
      r.received  = (was != CODE_NONE);
      r.is_repeat = (was == CODE_REPEAT);
      r.address   = shown_addr;
      r.command   = shown_cmd;
      poll_replies.push_back(r);
    endfunction

    function void check_reply(res_t got);
      res_t want;
      if (poll_replies.size() == 0) begin
        $error("reply with no poll outstanding: %h", got);
        errors++;
        return;
      end
      want = poll_replies.pop_front();
      replies++;
      if (want.received && !want.is_repeat) frames++;
      if (want.is_repeat) repeats++;
      if (got.received !== want.received) begin
        $error("received: expected %0d, got %0d", want.received, got.received);
        errors++;
      end
      if (got.is_repeat !== want.is_repeat) begin
        $error("is_repeat: expected %0d, got %0d", want.is_repeat, got.is_repeat);
        errors++;
      end
      if (got.address !== want.address) begin
        $error("address: expected %h, got %h", want.address, got.address);
        errors++;
      end
      if (got.command !== want.command) begin
        $error("command: expected %h, got %h", want.command, got.command);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/sv/nec_ir_decoder_tb.sv]
`timescale 1ns / 1ps

module nec_ir_decoder_tb;

  import necir_pkg::*;
  import ir_check_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = '0;
  logic [31:0] cfg_wdata_i   = '0;

  ir_poll_checker sb = new();

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int          hold_left      = 0;
  int          sent           = 0;
  int          settings       = 0;
  logic [31:0] now_stamp      = '0;

  nec_ir_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // result side: check each transfer, stall at random or hold off on request
  initial begin : sink
    res_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        got.received  = m_axis_tuser[0];
        got.is_repeat = m_axis_tuser[1];
        got.address   = m_axis_tdata[15:0];
        got.command   = m_axis_tdata[23:16];
        sb.check_reply(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_item(input logic kind_bit, input logic [31:0] stamp, input logic mark);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    s_axis_tuser  <= {mark, kind_bit};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_transfer(kind_bit, stamp, mark);
    sent++;
  endtask

  task automatic poll();
    send_item(KIND_POLL, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic send_pulse(input logic [31:0] width, input logic mark);
    now_stamp = now_stamp + width;
    send_item(KIND_EDGE, now_stamp, mark);
  endtask

  // in tolerance with the bounds favoured, or just outside when spoilt
  function automatic logic [31:0] pulse_width(input logic [15:0] nom, input bit spoil);
    logic [31:0] n, tol;
    int unsigned pick;
    n    = {16'h0, nom};
    tol  = n >> 2;
    pick = $urandom_range(99);
    if (spoil) return pick < 50 ? n - tol - 1 : n + tol + 1;
    if (pick < 10) return n - tol;
    if (pick < 20) return n + tol;
    return n - tol + $urandom_range(2 * tol);
  endfunction

  function automatic logic [31:0] random_code();
    logic [7:0]  a, c;
    logic [15:0] ext;
    int unsigned pick;
    a    = 8'($urandom);
    c    = 8'($urandom);
    ext  = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) return {~c, c, ~a, a};
    if (pick < 85) return {~c, c, ext};
    return $urandom;
  endfunction

  // gap, leader, frame space, nbits data bits, end mark if nbits >= 32; spoil_at picks one bad pulse
  task automatic send_frame(input logic [31:0] bits, input int nbits, input int spoil_at);
    int k;
    send_pulse($urandom_range(99) < 5 ? $urandom : $urandom_range(2000, 40000), 1'b0);
    send_pulse(pulse_width(sb.cfg.leader_mark, spoil_at == 0), 1'b1);
    send_pulse(pulse_width(sb.cfg.frame_space, spoil_at == 1), 1'b0);
    for (k = 0; k < nbits; k++) begin
      send_pulse(pulse_width(sb.cfg.bit_mark, spoil_at == 2 + 2 * k), 1'b1);
      send_pulse(pulse_width(bits[k % 32] ? sb.cfg.one_space : sb.cfg.zero_space,
                             spoil_at == 3 + 2 * k), 1'b0);
    end
    if (nbits >= 32) send_pulse(pulse_width(sb.cfg.bit_mark, spoil_at == 2 + 2 * nbits), 1'b1);
  endtask

  // aim places the closing mark exactly goal after the last frame or repeat, if time allows
  task automatic send_repeat(input bit aim, input logic [31:0] goal);
    logic [31:0] lw, rw, bw, gap;
    logic [32:0] spent;
    lw    = pulse_width(sb.cfg.leader_mark, 1'b0);
    rw    = pulse_width(sb.cfg.repeat_space, 1'b0);
    bw    = pulse_width(sb.cfg.bit_mark, 1'b0);
    spent = 33'(lw) + 33'(rw) + 33'(bw) + 33'(now_stamp - sb.held_since);
    if (aim && spent <= 33'(goal)) gap = goal - spent[31:0];
    else gap = $urandom_range(2000, 120000);
    send_pulse(gap, 1'b0);
    send_pulse(lw, 1'b1);
    send_pulse(rw, 1'b0);
    send_pulse(bw, 1'b1);
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(3) == 0) poll();
      else send_pulse($urandom_range(1) ? $urandom_range(20000) : $urandom,
                      1'($urandom_range(1)));
    end
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (sb.poll_replies.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic put_reg(input reg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // upper halves of the 16-bit registers carry junk that must be dropped
  task automatic set_timing(input logic [15:0] lm, fs, rs, bm, zs, os,
                            input logic [31:0] win);
    put_reg(REG_LEADER_MARK,   {16'($urandom), lm});
    put_reg(REG_FRAME_SPACE,   {16'($urandom), fs});
    put_reg(REG_REPEAT_SPACE,  {16'($urandom), rs});
    put_reg(REG_BIT_MARK,      {16'($urandom), bm});
    put_reg(REG_ZERO_SPACE,    {16'($urandom), zs});
    put_reg(REG_ONE_SPACE,     {16'($urandom), os});
    put_reg(REG_REPEAT_WINDOW, win);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic run_mix(input int budget);
    int          goal;
    int unsigned pick;
    logic [31:0] aim_at;
    goal = sent + budget;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_frame(random_code(), 32, -1);
        if ($urandom_range(9) < 7) poll();
      end else if (pick < 55) begin
        aim_at = $urandom_range(1) ? sb.cfg.repeat_window : sb.cfg.repeat_window - 1;
        send_repeat($urandom_range(3) == 0, aim_at);
        if ($urandom_range(9) < 7) poll();
      end else if (pick < 65) begin
        send_frame(random_code(), 32, $urandom_range(66));
      end else if (pick < 71) begin
        send_frame(random_code(), $urandom_range(31), -1);
      end else if (pick < 74) begin
        send_frame(random_code(), 33, -1);
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 3)) poll();
      end else if (pick < 98) begin
        noise();
      end else begin
        quiesce();
      end
    end
  endtask

  task automatic set_pace(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timings, directed cases
    poll();
    send_item(KIND_POLL, 32'hFFFF_FFFF, 1'b1);
    send_frame(32'h00FF_FF00, 32, -1);
    poll();
    send_repeat(1'b0, '0);
    poll();
    send_frame(32'h1234_5678, 32, -1);
    poll();
    send_frame(32'h10EF_3412, 32, -1);
    send_repeat(1'b0, '0);
    poll();
    poll();
    send_repeat(1'b1, sb.cfg.repeat_window);
    poll();
    send_repeat(1'b1, sb.cfg.repeat_window - 1);
    poll();
    send_frame(32'h00FF_00FF, 33, -1);
    poll();
    send_frame(32'h00FF_00FF, 32, -1);
    poll();
    send_frame(32'h7F80_FE01, 32, 20);
    poll();
    send_frame(32'hB44B_6699, 10, -1);
    send_frame(32'hB44B_6699, 32, -1);
    poll();
    run_mix(200);
    quiesce();

    set_pace(64, 0);
    set_timing('0, '0, '0, '0, '0, '0, '0);
    run_mix(200);
    quiesce();

    set_pace(0, 64);
    set_timing('1, '1, '1, '1, '1, '1, '1);
    run_mix(200);
    quiesce();

    set_pace(29, 29);
    set_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), $urandom);
    run_mix(200);
    quiesce();

    // halved timings; a long receiver hold-off backs the block up
    set_pace(0, 0);
    set_timing(16'd4500, 16'd2250, 16'd1125, 16'd281, 16'd281, 16'd843, 32'd150000);
    hold_req = 1'b1;
    repeat (8) poll();
    send_frame(random_code(), 32, -1);
    repeat (8) poll();
    set_pace(29, 29);
    run_mix(200);
    quiesce();

    set_pace(0, 0);
    set_timing(LEADER_MARK_RST, FRAME_SPACE_RST, REPEAT_SPACE_RST, BIT_MARK_RST,
               ZERO_SPACE_RST, ONE_SPACE_RST, REPEAT_WINDOW_RST);
    run_mix(200);

    s_axis_tvalid <= 1'b0;
    sink_stall_pct = 0;
    while (sb.poll_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d input transfers under %0d timing settings", sent, settings);
    $display("checked %0d replies: %0d frames and %0d repeats collected",
             sb.replies, sb.frames, sb.repeats);
    if (sb.errors == 0 && sb.poll_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[nec_ir_decoder.f]
hdl/necir_pkg.sv
hdl/necir_cfg.sv
hdl/necir_core.sv
hdl/nec_ir_decoder.sv
tb/sv/ir_check_pkg.sv
tb/sv/nec_ir_decoder_tb.sv
